FILE: rtl/spq_pkg.sv
// Package for the stable priority queue: entry and control types, sizes.
// No dependencies; used by spq_cell and stable_priority_queue_core.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    // number of cells in the chain
    localparam int DEPTH = 16;
    // count register holds 0..DEPTH
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OCC_W = 5;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef struct packed {
        logic [7:0]         prio;
        logic [7:0]         status;
        logic signed [31:0] amt;
        logic [7:0]         sys;
        logic [7:0]         res;
    } entry_t;

    // broadcast to every cell in the accepting cycle
    typedef struct packed {
        logic   push;   // push that fits
        logic   pop;    // pop of a non-empty queue
        entry_t item;   // word being pushed
    } cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/stable_priority_queue_core.sv
// Top level of the stable priority queue: cell chain, count and result register.
// Depends on spq_pkg and spq_cell.
`timescale 1ns / 1ps
`default_nettype none

// Sorted queue of up to DEPTH events, highest priority at the head, equal
// priorities in arrival order. A command word is taken on any cycle with
// start high; busy never rises, since every cell of the chain compares and
// shifts in the same cycle, so one word per cycle is sustained. Each word
// yields exactly one result, shown on the out_* ports with done high for a
// single cycle, in the cycle after the word was taken. The receiver cannot
// stall: capture the result when done is high. A push to a full queue is
// dropped and reported with refused; a pop of an empty queue returns
// popped low and zero fields. occupancy is the count after the word.
module stable_priority_queue_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        command,
    input  wire logic [7:0]  priority_req,
    input  wire logic [7:0]  status_code,
    input  wire logic signed [31:0] amount,
    input  wire logic [7:0]  system_id,
    input  wire logic [7:0]  resource_id,
    output logic             done,
    output logic             popped,
    output logic             refused,
    output logic [7:0]       out_priority,
    output logic [7:0]       out_status_code,
    output logic signed [31:0] out_amount,
    output logic [7:0]       out_system_id,
    output logic [7:0]       out_resource_id,
    output logic [spq_pkg::OCC_W-1:0] occupancy
);
    import spq_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    logic             popped_reg;
    logic             popped_next;
    logic             refused_reg;
    logic             refused_next;
    entry_t           head_reg;
    entry_t           head_next;
    logic [OCC_W-1:0] occ_reg;

    cell_ctl_t        ctl;
    logic             accept;
    logic             full;
    logic             empty;

    entry_t           cell_entry [DEPTH];
    logic             cell_keep  [DEPTH];
    logic             cell_occ   [DEPTH];

    // the whole chain settles in the accepting cycle
    assign busy   = 1'b0;
    assign accept = start;
    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);

    always_comb
    begin
        ctl.item.prio   = priority_req;
        ctl.item.status = status_code;
        ctl.item.amt    = amount;
        ctl.item.sys    = system_id;
        ctl.item.res    = resource_id;
        ctl.push        = accept && (command == CMD_PUSH) && !full;
        ctl.pop         = accept && (command == CMD_POP) && !empty;
    end

    // cell chain: head is cell 0
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign cell_occ[i] = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_head
            if (DEPTH > 1)
            begin : g_more
                spq_cell u_cell (
                    .clk         (clk),
                    .ctl         (ctl),
                    .occupied    (cell_occ[i]),
                    .left_keep   (1'b1),
                    .left_entry  (ctl.item),
                    .right_entry (cell_entry[i+1]),
                    .entry       (cell_entry[i]),
                    .keep        (cell_keep[i])
                );
            end
            else
            begin : g_only
                spq_cell u_cell (
                    .clk         (clk),
                    .ctl         (ctl),
                    .occupied    (cell_occ[i]),
                    .left_keep   (1'b1),
                    .left_entry  (ctl.item),
                    .right_entry (entry_t'('0)),
                    .entry       (cell_entry[i]),
                    .keep        (cell_keep[i])
                );
            end
        end
        else if (i == DEPTH - 1)
        begin : g_tail
            spq_cell u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .occupied    (cell_occ[i]),
                .left_keep   (cell_keep[i-1]),
                .left_entry  (cell_entry[i-1]),
                .right_entry (entry_t'('0)),
                .entry       (cell_entry[i]),
                .keep        (cell_keep[i])
            );
        end
        else
        begin : g_mid
            spq_cell u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .occupied    (cell_occ[i]),
                .left_keep   (cell_keep[i-1]),
                .left_entry  (cell_entry[i-1]),
                .right_entry (cell_entry[i+1]),
                .entry       (cell_entry[i]),
                .keep        (cell_keep[i])
            );
        end
    end

    // result word, formed from the state before the update
    always_comb
    begin
        count_next   = count_reg;
        popped_next  = 1'b0;
        refused_next = 1'b0;
        head_next    = '0;
        if (ctl.push)
            count_next = count_reg + CNT_W'(1);
        if (ctl.pop)
        begin
            count_next  = count_reg - CNT_W'(1);
            popped_next = 1'b1;
            head_next   = cell_entry[0];
        end
        if (accept && (command == CMD_PUSH) && full)
            refused_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    // payload of the result: no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            popped_reg  <= popped_next;
            refused_reg <= refused_next;
            head_reg    <= head_next;
            occ_reg     <= OCC_W'(count_next);
        end
    end

    assign done            = done_reg;
    assign popped          = popped_reg;
    assign refused         = refused_reg;
    assign out_priority    = head_reg.prio;
    assign out_status_code = head_reg.status;
    assign out_amount      = head_reg.amt;
    assign out_system_id   = head_reg.sys;
    assign out_resource_id = head_reg.res;
    assign occupancy       = occ_reg;

endmodule

`default_nettype wire

FILE: rtl/spq_cell.sv
// One cell of the sorted chain: holds one entry, compares against the pushed word.
// Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
    input  wire logic             clk,
    input  wire spq_pkg::cell_ctl_t ctl,
    input  wire logic             occupied,   // this cell holds a live entry
    input  wire logic             left_keep,  // left neighbor stays put (tied high at head)
    input  wire spq_pkg::entry_t  left_entry,
    input  wire spq_pkg::entry_t  right_entry,
    output spq_pkg::entry_t       entry,
    output logic                  keep
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // ties (equal priority) stay ahead of the new word
    assign keep  = occupied && (entry_reg.prio >= ctl.item.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.push)
        begin
            if (keep)
                entry_next = entry_reg;
            else if (left_keep)
                entry_next = ctl.item;
            else
                entry_next = left_entry;
        end
        else if (ctl.pop)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

FILE: test/stable_priority_queue_checker.sv
// Result checker for the stable priority queue: keeps its own sorted store,
// predicts one result per accepted word and compares it with the done stream.
// Depends on spq_pkg.
`timescale 1ns / 1ps

module stable_priority_queue_checker
    import spq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic        command,
    input  wire logic [7:0]  priority_req,
    input  wire logic [7:0]  status_code,
    input  wire logic signed [31:0] amount,
    input  wire logic [7:0]  system_id,
    input  wire logic [7:0]  resource_id,
    input  wire logic        done,
    input  wire logic        popped,
    input  wire logic        refused,
    input  wire logic [7:0]  out_priority,
    input  wire logic [7:0]  out_status_code,
    input  wire logic signed [31:0] out_amount,
    input  wire logic [7:0]  out_system_id,
    input  wire logic [7:0]  out_resource_id,
    input  wire logic [OCC_W-1:0] occupancy,
    output int               errors,
    output int               outstanding
);

    typedef struct packed {
        logic             popped;
        logic             refused;
        entry_t           head;
        logic [OCC_W-1:0] occ;
    } queue_result_t;

    entry_t        sorted_events [DEPTH];
    int            event_count;
    queue_result_t awaited_results [$];

    // insert behind equal or higher priorities, or take the head
    function automatic queue_result_t apply_command(logic cmd, entry_t item);
        queue_result_t r;
        int            pos;
        int            i;
        r = '0;
        if (cmd == CMD_PUSH) begin
            if (event_count >= DEPTH) begin
                r.refused = 1'b1;
            end
            else begin
                pos = 0;
                while (pos < event_count && sorted_events[pos].prio >= item.prio)
                    pos++;
                for (i = event_count; i > pos; i--)
                    sorted_events[i] = sorted_events[i - 1];
                sorted_events[pos] = item;
                event_count++;
            end
        end
        else if (event_count > 0) begin
            r.popped = 1'b1;
            r.head   = sorted_events[0];
            for (i = 1; i < event_count; i++)
                sorted_events[i - 1] = sorted_events[i];
            event_count--;
        end
        r.occ = OCC_W'(event_count);
        return r;
    endfunction

    task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %h actual %h", $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        queue_result_t want;
        entry_t        item;
        if (!rst_n) begin
            event_count = 0;
            awaited_results.delete();
        end
        else begin
            // compare before taking a new word: a result never shares its word's edge
            if (done) begin
                if (awaited_results.size() == 0) begin
                    errors++;
                    $display("%0t: result with none expected, occupancy actual %0d",
                             $time, occupancy);
                end
                else begin
                    want = awaited_results.pop_front();
                    check_field("popped", 32'(want.popped), 32'(popped));
                    check_field("refused", 32'(want.refused), 32'(refused));
                    check_field("out_priority", 32'(want.head.prio), 32'(out_priority));
                    check_field("out_status_code", 32'(want.head.status),
                                32'(out_status_code));
                    check_field("out_amount", want.head.amt, out_amount);
                    check_field("out_system_id", 32'(want.head.sys), 32'(out_system_id));
                    check_field("out_resource_id", 32'(want.head.res),
                                32'(out_resource_id));
                    check_field("occupancy", 32'(want.occ), 32'(occupancy));
                end
            end
            if (start && !busy) begin
                item.prio   = priority_req;
                item.status = status_code;
                item.amt    = amount;
                item.sys    = system_id;
                item.res    = resource_id;
                awaited_results.push_back(apply_command(command, item));
            end
        end
        outstanding = awaited_results.size();
    end

endmodule

FILE: test/tb_stable_priority_queue_core.sv
// Testbench top for stable_priority_queue_core: clock, reset, command words,
// watchdog and verdict. Depends on spq_pkg, the core and stable_priority_queue_checker.
`timescale 1ns / 1ps

module tb_stable_priority_queue_core;

    import spq_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_WORDS    = 584;   // three phases, about 1750 words

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        command = CMD_PUSH;
    logic [7:0]  priority_req = '0;
    logic [7:0]  status_code = '0;
    logic signed [31:0] amount = '0;
    logic [7:0]  system_id = '0;
    logic [7:0]  resource_id = '0;

    wire logic        busy;
    wire logic        done;
    wire logic        popped;
    wire logic        refused;
    wire logic [7:0]  out_priority;
    wire logic [7:0]  out_status_code;
    wire logic signed [31:0] out_amount;
    wire logic [7:0]  out_system_id;
    wire logic [7:0]  out_resource_id;
    wire logic [OCC_W-1:0] occupancy;

    int errors;
    int outstanding;
    int quiet_cycles = 0;
    int idle_pct = 0;      // chance in percent that the sender skips a cycle

    always #4 clk = ~clk;

    stable_priority_queue_core u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .command         (command),
        .priority_req    (priority_req),
        .status_code     (status_code),
        .amount          (amount),
        .system_id       (system_id),
        .resource_id     (resource_id),
        .done            (done),
        .popped          (popped),
        .refused         (refused),
        .out_priority    (out_priority),
        .out_status_code (out_status_code),
        .out_amount      (out_amount),
        .out_system_id   (out_system_id),
        .out_resource_id (out_resource_id),
        .occupancy       (occupancy)
    );

    // Checker sits on the same wires as the core; it owns all prediction.
    stable_priority_queue_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .command         (command),
        .priority_req    (priority_req),
        .status_code     (status_code),
        .amount          (amount),
        .system_id       (system_id),
        .resource_id     (resource_id),
        .done            (done),
        .popped          (popped),
        .refused         (refused),
        .out_priority    (out_priority),
        .out_status_code (out_status_code),
        .out_amount      (out_amount),
        .out_system_id   (out_system_id),
        .out_resource_id (out_resource_id),
        .occupancy       (occupancy),
        .errors          (errors),
        .outstanding     (outstanding)
    );

    // Watchdog: any accepted word or result counts as progress. A hang on
    // either side shows up as a long quiet stretch.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_stable_priority_queue_core: errors");
            $finish;
        end
    end

    function automatic entry_t make_event(logic [7:0] prio, logic [7:0] status,
                                          logic [31:0] amt, logic [7:0] sys,
                                          logic [7:0] res);
        entry_t e;
        e.prio   = prio;
        e.status = status;
        e.amt    = amt;
        e.sys    = sys;
        e.res    = res;
        return e;
    endfunction

    // Priorities lean toward a tiny set so that ties (FIFO order) are common;
    // the rest spread over the full range with the two extremes called out.
    function automatic entry_t random_event();
        int     pick;
        entry_t e;
        pick = $urandom_range(9);
        if (pick < 5)
            e.prio = 8'($urandom_range(3));
        else if (pick < 8)
            e.prio = 8'($urandom);
        else
            e.prio = (pick == 8) ? 8'h00 : 8'hFF;
        e.status = 8'($urandom);
        e.amt    = $urandom;
        e.sys    = 8'($urandom);
        e.res    = 8'($urandom);
        return e;
    endfunction

    // Present one word and hold it until the core takes it. start stays high
    // across back-to-back words; it only drops in a sender gap.
    task automatic send_word(input logic cmd, input entry_t e);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        command      <= cmd;
        priority_req <= e.prio;
        status_code  <= e.status;
        amount       <= e.amt;
        system_id    <= e.sys;
        resource_id  <= e.res;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Sender goes quiet until every predicted result has come back.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
    endtask

    initial
    begin
        int     i;
        int     phase;
        int     push_pct;
        logic   cmd;
        entry_t e;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---
        // pop of an empty queue
        send_word(CMD_POP, make_event(8'h00, 8'h00, 32'h0, 8'h00, 8'h00));
        // extremes of every field, and ties at a middle and at the highest priority
        send_word(CMD_PUSH, make_event(8'd5, 8'h00, 32'h0000_0000, 8'h00, 8'h00));
        send_word(CMD_PUSH, make_event(8'hFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF));
        send_word(CMD_PUSH, make_event(8'h00, 8'h01, 32'h8000_0000, 8'h01, 8'h01));
        send_word(CMD_PUSH, make_event(8'd5, 8'h02, 32'h7FFF_FFFF, 8'h02, 8'h02));
        send_word(CMD_PUSH, make_event(8'hFF, 8'h03, 32'h0000_0001, 8'h03, 8'h03));
        // fill to capacity with a spread of small priorities
        for (i = 0; i < DEPTH - 5; i++)
            send_word(CMD_PUSH, make_event(8'(i % 4), 8'(i + 16), 32'(i * 1000 - 3),
                                           8'(i), 8'(255 - i)));
        // push into a full queue is refused
        send_word(CMD_PUSH, make_event(8'hFF, 8'hAA, 32'h5555_5555, 8'hAA, 8'h55));
        // take the two highest pairs off in arrival order
        for (i = 0; i < 4; i++)
            send_word(CMD_POP, make_event(8'h00, 8'h00, 32'h0, 8'h00, 8'h00));
        send_word(CMD_PUSH, make_event(8'hFF, 8'h44, 32'h1234_5678, 8'h44, 8'h44));

        // --- random part ---
        // Phase 0: sender skips 7% of cycles, phase 1: 67%, phase 2: never.
        // Every 32 words the push bias flips between filling, draining and
        // balanced, so full and empty are both visited many times.
        for (phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 7 : (phase == 1) ? 67 : 0;
            push_pct = 50;
            for (i = 0; i < PHASE_WORDS; i++) begin
                if (i % 32 == 0) begin
                    case ($urandom_range(2))
                        0:       push_pct = 85;
                        1:       push_pct = 15;
                        default: push_pct = 50;
                    endcase
                end
                if ($urandom_range(199) == 0)
                    drain_results();
                cmd = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP;
                e   = random_event();
                send_word(cmd, e);
            end
            drain_results();
        end

        // let anything late or stray show up before the verdict
        repeat (4) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("tb_stable_priority_queue_core: clean");
        else
            $display("tb_stable_priority_queue_core: errors");
        $finish;
    end

endmodule

FILE: stable_priority_queue_core.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_priority_queue_core.sv
test/stable_priority_queue_checker.sv
test/tb_stable_priority_queue_core.sv
